// ===== rtl/core/assert_macros.svh =====
// Assertion helpers used by the top-level RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define CAU_ASSERT_IMP(lbl, ck, rn, ante, cons, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) (ante) |-> (cons)) \
		else $error(msg);

// Condition that must never be seen outside reset.
`define CAU_ASSERT_NEVER(lbl, ck, rn, cond, msg) \
	lbl: assert property (@(posedge ck) disable iff (!(rn)) !(cond)) \
		else $error(msg);

`endif

// ===== rtl/core/cau_pkg.sv =====
`default_nettype none

package cau_pkg;

	// Word format: signed fixed point, W bits with F fraction bits
	localparam int W  = 16;
	localparam int F  = 8;
	localparam int PW = 2 * W;       // product and sum-of-squares width
	localparam int QB = W + F + 1;   // quotient bits, one guard bit for rounding

	localparam logic [W-1:0] SMAX = {1'b0, {(W-1){1'b1}}};
	localparam logic [W-1:0] SMIN = {1'b1, {(W-1){1'b0}}};

	// Magnitude limits for packing a sign/magnitude value
	localparam logic [PW:0] LIM_POS = {{(PW+2-W){1'b0}}, {(W-1){1'b1}}};
	localparam logic [PW:0] LIM_NEG = LIM_POS + (PW+1)'(1);
	localparam logic [PW:0] HALF    = (F == 0) ? '0 : ((PW+1)'(1) << ((F == 0) ? 0 : F - 1));
	localparam logic [PW:0] OVF_MAG = (PW+1)'(1) << W;

	typedef enum logic [2:0] {
		OP_ADD = 3'd0,
		OP_SUB = 3'd1,
		OP_MUL = 3'd2,
		OP_DIV = 3'd3,
		OP_MAG = 3'd4
	} op_t;

	typedef struct packed {
		logic         sat;
		logic [W-1:0] val;
	} pack_t;

	// Result fields settled early in the pipe (add, subtract, multiply)
	typedef struct packed {
		logic [2:0]   kind;
		logic         eq;
		logic [W-1:0] re;
		logic [W-1:0] im;
		logic         sat;
	} cau_base_t;

	// Word carried through the divide / square root stages
	typedef struct packed {
		cau_base_t     base;
		logic          dz;
		logic          neg_re;
		logic          neg_im;
		logic          ovf_re;
		logic          ovf_im;
		logic [PW-1:0] den;
		logic [PW-1:0] rem_re;
		logic [PW-1:0] rem_im;
		logic [QB-1:0] dl_re;
		logic [QB-1:0] dl_im;
		logic [QB-1:0] q_re;
		logic [QB-1:0] q_im;
		logic [PW-1:0] sq_x;
		logic [W-1:0]  sq_r;
	} cau_it_t;

	typedef struct packed {
		logic [W-1:0] re;
		logic [W-1:0] im;
		logic         eq;
		logic         dz;
		logic         sat;
	} cau_res_t;

	// Clamp a W+1 bit sum to W bits
	function automatic pack_t sat_add(input logic [W:0] v);
		pack_t p;
		if (v[W] != v[W-1]) begin
			p.sat = 1'b1;
			p.val = v[W] ? SMIN : SMAX;
		end else begin
			p.sat = 1'b0;
			p.val = v[W-1:0];
		end
		return p;
	endfunction

	// Round to nearest, ties away from zero, dropping F bits of a magnitude
	function automatic logic [PW:0] round_sh(input logic [PW-1:0] mag);
		return ({1'b0, mag} + HALF) >> F;
	endfunction

	// Apply sign to a magnitude and saturate to W bits
	function automatic pack_t round_pack(input logic neg, input logic [PW:0] mag);
		pack_t p;
		p.sat = 1'b0;
		if (neg) begin
			if (mag > LIM_NEG) begin
				p.sat = 1'b1;
				p.val = SMIN;
			end else begin
				p.val = -mag[W-1:0];
			end
		end else begin
			if (mag > LIM_POS) begin
				p.sat = 1'b1;
				p.val = SMAX;
			end else begin
				p.val = mag[W-1:0];
			end
		end
		return p;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/cau_front.sv =====
`default_nettype none

// Front end: products, sums, magnitudes, then set-up of the divide/root word
module cau_front import cau_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [2:0]          kind,
	input  wire logic signed [W-1:0] a_re,
	input  wire logic signed [W-1:0] a_im,
	input  wire logic signed [W-1:0] b_re,
	input  wire logic signed [W-1:0] b_im,
	output logic                     out_valid,
	output cau_it_t                  out_data,
	input  wire logic                out_ready
);

	logic rdy1, rdy2, rdy3, rdy4;

	// stage 1: multipliers, add/subtract with clamp
	logic                 v_s1;
	cau_base_t            base_s1;
	logic signed [PW-1:0] p_rr_s1, p_ii_s1, p_ri_s1, p_ir_s1;
	logic signed [PW-1:0] p_aa_s1, p_ab_s1, p_bb_s1, p_bc_s1;

	logic signed [W:0] add_re, add_im, sub_re, sub_im;
	pack_t             c_re, c_im;
	cau_base_t         base_n1;

	always_comb begin
		add_re  = {a_re[W-1], a_re} + {b_re[W-1], b_re};
		add_im  = {a_im[W-1], a_im} + {b_im[W-1], b_im};
		sub_re  = {a_re[W-1], a_re} - {b_re[W-1], b_re};
		sub_im  = {a_im[W-1], a_im} - {b_im[W-1], b_im};
		base_n1 = '0;
		base_n1.kind = kind;
		base_n1.eq   = (a_re == b_re) && (a_im == b_im);
		c_re = '0;
		c_im = '0;
		case (op_t'(kind))
			OP_ADD: begin
				c_re = sat_add(add_re);
				c_im = sat_add(add_im);
			end
			OP_SUB: begin
				c_re = sat_add(sub_re);
				c_im = sat_add(sub_im);
			end
			default: begin
				c_re = '0;
				c_im = '0;
			end
		endcase
		base_n1.re  = c_re.val;
		base_n1.im  = c_im.val;
		base_n1.sat = c_re.sat | c_im.sat;
	end

	assign rdy1 = ~v_s1 | rdy2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy1) begin
			v_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			base_s1 <= base_n1;
			p_rr_s1 <= a_re * b_re;
			p_ii_s1 <= a_im * b_im;
			p_ri_s1 <= a_re * b_im;
			p_ir_s1 <= a_im * b_re;
			p_aa_s1 <= a_re * a_re;
			p_ab_s1 <= a_im * a_im;
			p_bb_s1 <= b_re * b_re;
			p_bc_s1 <= b_im * b_im;
		end
	end

	// stage 2: sums of products
	logic              v_s2;
	cau_base_t         base_s2;
	logic signed [PW:0] m_re_s2, m_im_s2, n_re_s2, n_im_s2;
	logic [PW-1:0]     den_s2, sq_s2;

	assign rdy2 = ~v_s2 | rdy3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy2) begin
			base_s2 <= base_s1;
			m_re_s2 <= {p_rr_s1[PW-1], p_rr_s1} - {p_ii_s1[PW-1], p_ii_s1};
			m_im_s2 <= {p_ri_s1[PW-1], p_ri_s1} + {p_ir_s1[PW-1], p_ir_s1};
			n_re_s2 <= {p_rr_s1[PW-1], p_rr_s1} + {p_ii_s1[PW-1], p_ii_s1};
			n_im_s2 <= {p_ir_s1[PW-1], p_ir_s1} - {p_ri_s1[PW-1], p_ri_s1};
			den_s2  <= p_bb_s1 + p_bc_s1;
			sq_s2   <= p_aa_s1 + p_ab_s1;
		end
	end

	// stage 3: sign and magnitude
	logic          v_s3;
	cau_base_t     base_s3;
	logic          ng_mre_s3, ng_mim_s3, ng_nre_s3, ng_nim_s3;
	logic [PW-1:0] mg_mre_s3, mg_mim_s3, mg_nre_s3, mg_nim_s3;
	logic [PW-1:0] den_s3, sq_s3;

	assign rdy3 = ~v_s3 | rdy4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (rdy3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy3) begin
			base_s3   <= base_s2;
			ng_mre_s3 <= m_re_s2[PW];
			ng_mim_s3 <= m_im_s2[PW];
			ng_nre_s3 <= n_re_s2[PW];
			ng_nim_s3 <= n_im_s2[PW];
			mg_mre_s3 <= m_re_s2[PW] ? PW'(-m_re_s2) : m_re_s2[PW-1:0];
			mg_mim_s3 <= m_im_s2[PW] ? PW'(-m_im_s2) : m_im_s2[PW-1:0];
			mg_nre_s3 <= n_re_s2[PW] ? PW'(-n_re_s2) : n_re_s2[PW-1:0];
			mg_nim_s3 <= n_im_s2[PW] ? PW'(-n_im_s2) : n_im_s2[PW-1:0];
			den_s3    <= den_s2;
			sq_s3     <= sq_s2;
		end
	end

	// stage 4: multiply rounding, divide set-up
	logic    v_s4;
	cau_it_t it_s4;
	cau_it_t it_n4;
	pack_t   pm_re, pm_im;

	always_comb begin
		pm_re = round_pack(ng_mre_s3, round_sh(mg_mre_s3));
		pm_im = round_pack(ng_mim_s3, round_sh(mg_mim_s3));
		it_n4 = '0;
		it_n4.base = base_s3;
		if (op_t'(base_s3.kind) == OP_MUL) begin
			it_n4.base.re  = pm_re.val;
			it_n4.base.im  = pm_im.val;
			it_n4.base.sat = pm_re.sat | pm_im.sat;
		end
		it_n4.dz     = (op_t'(base_s3.kind) == OP_DIV) && (den_s3 == '0);
		it_n4.neg_re = ng_nre_s3;
		it_n4.neg_im = ng_nim_s3;
		// quotient would need more than W integer bits
		it_n4.ovf_re = PW'(mg_nre_s3[PW-1:W]) >= den_s3;
		it_n4.ovf_im = PW'(mg_nim_s3[PW-1:W]) >= den_s3;
		it_n4.den    = den_s3;
		it_n4.rem_re = PW'(mg_nre_s3[PW-1:W]);
		it_n4.rem_im = PW'(mg_nim_s3[PW-1:W]);
		it_n4.dl_re  = {mg_nre_s3[W-1:0], {(F+1){1'b0}}};
		it_n4.dl_im  = {mg_nim_s3[W-1:0], {(F+1){1'b0}}};
		it_n4.sq_x   = sq_s3;
	end

	assign rdy4 = ~v_s4 | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else if (rdy4) begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy4) begin
			it_s4 <= it_n4;
		end
	end

	assign in_ready  = rdy1;
	assign out_valid = v_s4;
	assign out_data  = it_s4;

endmodule

`default_nettype wire

// ===== rtl/core/cau_iter.sv =====
`default_nettype none

// Restoring divide (one quotient bit per stage, both parts) and
// digit-by-digit square root (one root bit per stage, first W stages)
module cau_iter import cau_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire cau_it_t in_data,
	output logic         out_valid,
	output cau_it_t      out_data,
	input  wire logic    out_ready
);

	logic    v_s  [QB];
	cau_it_t it_s [QB];
	wire     rdy  [QB+1];

	assign rdy[QB] = out_ready;

	for (genvar k = 0; k < QB; k++) begin : g_stage
		logic          src_v;
		cau_it_t       src;
		cau_it_t       nxt;
		logic [PW:0]   t_re, t_im;
		logic [PW-1:0] sx_n;
		logic [W-1:0]  sr_n;

		if (k == 0) begin : g_first
			assign src_v = in_valid;
			assign src   = in_data;
		end else begin : g_next
			assign src_v = v_s[k-1];
			assign src   = it_s[k-1];
		end

		// root bit W-1-k
		if (k < W) begin : g_root
			localparam int B = W - 1 - k;
			logic [PW:0] sq_t;
			always_comb begin
				sq_t = ((PW+1)'(src.sq_r) << (B + 1)) | ((PW+1)'(1) << (2 * B));
				if ({1'b0, src.sq_x} >= sq_t) begin
					sx_n = src.sq_x - sq_t[PW-1:0];
					sr_n = src.sq_r | (W'(1) << B);
				end else begin
					sx_n = src.sq_x;
					sr_n = src.sq_r;
				end
			end
		end else begin : g_hold
			assign sx_n = src.sq_x;
			assign sr_n = src.sq_r;
		end

		always_comb begin
			nxt  = src;
			t_re = {src.rem_re, src.dl_re[QB-1]};
			t_im = {src.rem_im, src.dl_im[QB-1]};
			if (t_re >= {1'b0, src.den}) begin
				nxt.rem_re = PW'(t_re - {1'b0, src.den});
				nxt.q_re   = {src.q_re[QB-2:0], 1'b1};
			end else begin
				nxt.rem_re = t_re[PW-1:0];
				nxt.q_re   = {src.q_re[QB-2:0], 1'b0};
			end
			if (t_im >= {1'b0, src.den}) begin
				nxt.rem_im = PW'(t_im - {1'b0, src.den});
				nxt.q_im   = {src.q_im[QB-2:0], 1'b1};
			end else begin
				nxt.rem_im = t_im[PW-1:0];
				nxt.q_im   = {src.q_im[QB-2:0], 1'b0};
			end
			nxt.dl_re = {src.dl_re[QB-2:0], 1'b0};
			nxt.dl_im = {src.dl_im[QB-2:0], 1'b0};
			nxt.sq_x  = sx_n;
			nxt.sq_r  = sr_n;
		end

		assign rdy[k] = ~v_s[k] | rdy[k+1];

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else if (rdy[k]) begin
				v_s[k] <= src_v;
			end
		end

		always_ff @(posedge clk) begin
			if (rdy[k]) begin
				it_s[k] <= nxt;
			end
		end
	end

	assign in_ready  = rdy[0];
	assign out_valid = v_s[QB-1];
	assign out_data  = it_s[QB-1];

endmodule

`default_nettype wire

// ===== rtl/core/cau_back.sv =====
`default_nettype none

// Final rounding of quotient and root, result select, output register
module cau_back import cau_pkg::*; (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    in_valid,
	output logic         in_ready,
	input  wire cau_it_t in_data,
	output logic         out_valid,
	output cau_res_t     out_data,
	input  wire logic    out_ready
);

	logic     v_q;
	cau_res_t res_q;
	cau_res_t res_n;

	logic [QB-1:0] qr_re, qr_im;
	logic [W:0]    root;
	pack_t         pd_re, pd_im, pr;

	always_comb begin
		// drop the guard bit with rounding
		qr_re = QB'(({1'b0, in_data.q_re} + (QB+1)'(1)) >> 1);
		qr_im = QB'(({1'b0, in_data.q_im} + (QB+1)'(1)) >> 1);
		pd_re = round_pack(in_data.neg_re, in_data.ovf_re ? OVF_MAG : (PW+1)'(qr_re));
		pd_im = round_pack(in_data.neg_im, in_data.ovf_im ? OVF_MAG : (PW+1)'(qr_im));
		// round the root up when the remainder exceeds it
		root  = {1'b0, in_data.sq_r} + (W+1)'(in_data.sq_x > PW'(in_data.sq_r));
		pr    = round_pack(1'b0, (PW+1)'(root));

		res_n    = '0;
		res_n.eq = in_data.base.eq;
		case (op_t'(in_data.base.kind))
			OP_DIV: begin
				if (in_data.dz) begin
					res_n.dz = 1'b1;
				end else begin
					res_n.re  = pd_re.val;
					res_n.im  = pd_im.val;
					res_n.sat = pd_re.sat | pd_im.sat;
				end
			end
			OP_MAG: begin
				res_n.re  = pr.val;
				res_n.sat = pr.sat;
			end
			default: begin
				res_n.re  = in_data.base.re;
				res_n.im  = in_data.base.im;
				res_n.sat = in_data.base.sat;
			end
		endcase
	end

	assign in_ready = ~v_q | out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= 1'b0;
		end else if (in_ready) begin
			v_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready) begin
			res_q <= res_n;
		end
	end

	assign out_valid = v_q;
	assign out_data  = res_q;

endmodule

`default_nettype wire

// ===== rtl/core/complex_arithmetic_unit_top.sv =====
// Complex arithmetic unit on signed Q7.8 operands: add, subtract, multiply,
// divide, or magnitude of a (kind 0 to 4; other codes give zero). One word is
// accepted per cycle while the output is not stalled, and each result passes
// through 4 front stages for products, sums and set-up, 25 divide stages at
// one quotient bit each, and the output register. Results round to nearest,
// ties away from zero, and saturate with the saturated flag; a zero divisor
// gives zero and div_by_zero. is_equal reports a == b for every code. Stalls
// on the output back up through the pipe, filling empty stages first, so
// nothing is dropped or repeated.
`default_nettype none

`include "assert_macros.svh"

module complex_arithmetic_unit_top import cau_pkg::*; (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic [2:0]          kind,
	input  wire logic signed [W-1:0] a_re,
	input  wire logic signed [W-1:0] a_im,
	input  wire logic signed [W-1:0] b_re,
	input  wire logic signed [W-1:0] b_im,
	output logic                     out_valid,
	input  wire logic                out_ready,
	output logic signed [W-1:0]      res_re,
	output logic signed [W-1:0]      res_im,
	output logic                     is_equal,
	output logic                     div_by_zero,
	output logic                     saturated
);

	logic     fr_valid, fr_ready;
	cau_it_t  fr_data;
	logic     it_valid, it_ready;
	cau_it_t  it_data;
	cau_res_t res;

	cau_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.a_re      (a_re),
		.a_im      (a_im),
		.b_re      (b_re),
		.b_im      (b_im),
		.out_valid (fr_valid),
		.out_data  (fr_data),
		.out_ready (fr_ready)
	);

	cau_iter u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (fr_valid),
		.in_ready  (fr_ready),
		.in_data   (fr_data),
		.out_valid (it_valid),
		.out_data  (it_data),
		.out_ready (it_ready)
	);

	cau_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (it_valid),
		.in_ready  (it_ready),
		.in_data   (it_data),
		.out_valid (out_valid),
		.out_data  (res),
		.out_ready (out_ready)
	);

	assign res_re      = res.re;
	assign res_im      = res.im;
	assign is_equal    = res.eq;
	assign div_by_zero = res.dz;
	assign saturated   = res.sat;

	// zero divisor gives a clean zero result
	`CAU_ASSERT_IMP(a_dz_zero, clk, arst_n, out_valid && div_by_zero, res_re == '0 && res_im == '0 && !saturated, "div by zero word not zero")
	// a clamped word holds an extreme value in one part
	`CAU_ASSERT_IMP(a_sat_rail, clk, arst_n, out_valid && saturated, res_re == SMAX || res_re == SMIN || res_im == SMAX || res_im == SMIN, "saturated word off the rails")
	// input only stalls when the output word is held
	`CAU_ASSERT_NEVER(a_no_false_stall, clk, arst_n, !in_ready && !(out_valid && !out_ready), "input stalled with room in the pipe")

endmodule

`default_nettype wire

// ===== tb/tb_complex_arithmetic_unit_top.sv =====
`default_nettype none

// Expected results of the unit, oldest first
class cau_scoreboard;
	typedef struct packed {
		logic [15:0] re;
		logic [15:0] im;
		logic        eq;
		logic        dz;
		logic        sat;
	} res_word_t;

	res_word_t pending[$];
	int        mismatches;
	int        spurious;

	function new();
		mismatches = 0;
		spurious = 0;
	endfunction

	// Apply sign to a magnitude (already rounded and shifted) and saturate to 16 bits
	static function logic [15:0] pack_val(input bit neg, input longint unsigned m,
			inout bit sat);
		if (neg) begin
			if (m > 64'd32768) begin
				sat = 1'b1;
				return 16'h8000;
			end
			return 16'(-longint'(m));
		end
		if (m > 64'd32767) begin
			sat = 1'b1;
			return 16'h7fff;
		end
		return 16'(m);
	endfunction

	static function logic [15:0] clamp17(input longint v, inout bit sat);
		if (v > 32767) begin
			sat = 1'b1;
			return 16'h7fff;
		end
		if (v < -32768) begin
			sat = 1'b1;
			return 16'h8000;
		end
		return 16'(v);
	endfunction

	// Rounded product part: (p + q) >> 8, ties away from zero
	static function logic [15:0] prod_part(input longint s, inout bit sat);
		bit neg;
		longint unsigned m;
		neg = s < 0;
		m = neg ? longint'(-s) : s;
		m = (m + 64'd128) >> 8;
		return pack_val(neg, m, sat);
	endfunction

	// Quotient part: s / den with 8 fraction bits and rounding
	static function logic [15:0] quot_part(input longint s, input longint unsigned den,
			inout bit sat);
		bit neg;
		longint unsigned m, q, r;
		neg = s < 0;
		m = neg ? longint'(-s) : s;
		q = m / den;
		r = m % den;
		if (q >= 64'd65536)
			return pack_val(neg, 64'd65536, sat);
		for (int i = 0; i < 9; i++) begin
			r = r << 1;
			q = q << 1;
			if (r >= den) begin
				r = r - den;
				q = q | 64'd1;
			end
		end
		return pack_val(neg, (q + 64'd1) >> 1, sat);
	endfunction

	static function longint unsigned sqrt_round(input longint unsigned s);
		longint unsigned x, res, b;
		x = s;
		res = 0;
		b = 64'd1 << 62;
		while (b > x)
			b = b >> 2;
		while (b != 0) begin
			if (x >= res + b) begin
				x = x - (res + b);
				res = (res >> 1) + b;
			end else begin
				res = res >> 1;
			end
			b = b >> 2;
		end
		if (x > res)
			res++;
		return res;
	endfunction

	// Note an accepted operand word and queue its expected result
	function void note_operands(input logic [2:0] k, input logic signed [15:0] ar_w,
			input logic signed [15:0] ai_w, input logic signed [15:0] br_w,
			input logic signed [15:0] bi_w);
		res_word_t r;
		bit sat;
		longint ar, ai, br, bi;
		longint unsigned den;
		ar = ar_w;
		ai = ai_w;
		br = br_w;
		bi = bi_w;
		sat = 1'b0;
		r = '0;
		r.eq = (ar == br) && (ai == bi);
		case (k)
			cau_pkg::OP_ADD: begin
				r.re = clamp17(ar + br, sat);
				r.im = clamp17(ai + bi, sat);
			end
			cau_pkg::OP_SUB: begin
				r.re = clamp17(ar - br, sat);
				r.im = clamp17(ai - bi, sat);
			end
			cau_pkg::OP_MUL: begin
				r.re = prod_part(ar * br - ai * bi, sat);
				r.im = prod_part(ar * bi + ai * br, sat);
			end
			cau_pkg::OP_DIV: begin
				den = br * br + bi * bi;
				if (den == 0) begin
					r.dz = 1'b1;
				end else begin
					r.re = quot_part(ar * br + ai * bi, den, sat);
					r.im = quot_part(ai * br - ar * bi, den, sat);
				end
			end
			cau_pkg::OP_MAG: begin
				r.re = pack_val(1'b0, sqrt_round(ar * ar + ai * ai), sat);
			end
			default: ;
		endcase
		r.sat = sat;
		pending.push_back(r);
	endfunction

	// Check a result word against the oldest expectation
	function void check_result(input res_word_t got);
		res_word_t want;
		if (pending.size() == 0) begin
			spurious++;
			if (mismatches + spurious <= 10)
				$display("unexpected result word re=%h im=%h", got.re, got.im);
			return;
		end
		want = pending.pop_front();
		if (got !== want) begin
			mismatches++;
			if (mismatches + spurious <= 10)
				$display("mismatch: exp re=%h im=%h eq=%b dz=%b sat=%b, got re=%h im=%h eq=%b dz=%b sat=%b",
					want.re, want.im, want.eq, want.dz, want.sat,
					got.re, got.im, got.eq, got.dz, got.sat);
		end
	endfunction
endclass

module tb_complex_arithmetic_unit_top;
	timeunit 1ns;
	timeprecision 1ps;
	import cau_pkg::*;

	localparam int RANDOM_WORDS = 1300;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 60;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [2:0] kind = '0;
	logic signed [W-1:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [W-1:0] res_re, res_im;
	logic is_equal, div_by_zero, saturated;

	cau_scoreboard results = new();
	bit calm = 1'b0;
	bit stall_done = 1'b0;
	int cycles = 0;

	complex_arithmetic_unit_top dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("tb: failure");
			$finish;
		end
	end

	// Receiver: random stall bursts, one long hold-off, none at the end
	initial begin
		int n;
		@(posedge arst_n);
		out_ready <= 1'b1;
		repeat (300) @(posedge clk);
		out_ready <= 1'b0;
		repeat (200) @(posedge clk);
		stall_done = 1'b1;
		forever begin
			@(posedge clk);
			if (!calm && $urandom_range(0, 3) == 0) begin
				n = $urandom_range(1, 6);
				out_ready <= 1'b0;
				repeat (n - 1) @(posedge clk);
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// Result monitor
	always @(posedge clk)
		if (arst_n && out_valid && out_ready)
			results.check_result({res_re, res_im, is_equal, div_by_zero, saturated});

	// Offer one operand word and hold it until accepted
	task automatic send_word(input logic [2:0] k, input logic [15:0] ar,
			input logic [15:0] ai, input logic [15:0] br, input logic [15:0] bi);
		int gap;
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		a_re <= ar;
		a_im <= ai;
		b_re <= br;
		b_im <= bi;
		do
			@(posedge clk);
		while (!in_ready);
		results.note_operands(k, ar, ai, br, bi);
	endtask

	// Operand value biased towards small and extreme values
	function automatic logic [15:0] pick_value();
		case ($urandom_range(0, 5))
			0: return 16'h7fff - 16'($urandom_range(0, 2));
			1: return 16'h8000 + 16'($urandom_range(0, 2));
			2: return 16'($signed($urandom_range(0, 1024)) - 512);
			3: return 16'($urandom_range(0, 2)) - 16'd1;
			default: return 16'($urandom);
		endcase
	endfunction

	initial begin
		logic [2:0] k;
		logic [15:0] ar, ai;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed words: extremes, each operation, zero divisor, unused codes
		send_word(OP_ADD, 16'h7fff, 16'h8000, 16'h0001, 16'hffff);
		send_word(OP_ADD, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		send_word(OP_ADD, 16'h0100, 16'h0200, 16'h0100, 16'h0200);
		send_word(OP_SUB, 16'h8000, 16'h7fff, 16'h0001, 16'hffff);
		send_word(OP_SUB, 16'h1234, 16'h1234, 16'h1234, 16'h1234);
		send_word(OP_MUL, 16'h8000, 16'h8000, 16'h8000, 16'h8000);
		send_word(OP_MUL, 16'h7fff, 16'h8000, 16'h7fff, 16'h7fff);
		send_word(OP_MUL, 16'h0080, 16'h0000, 16'h0001, 16'h0000);
		send_word(OP_MUL, 16'hff80, 16'h0000, 16'h0001, 16'h0000);
		send_word(OP_MUL, 16'h0100, 16'h0100, 16'h0100, 16'hff00);
		send_word(OP_DIV, 16'h0100, 16'h0200, 16'h0000, 16'h0000);
		send_word(OP_DIV, 16'h0000, 16'h0000, 16'h0000, 16'h0000);
		send_word(OP_DIV, 16'h7fff, 16'h7fff, 16'h0001, 16'h0000);
		send_word(OP_DIV, 16'h8000, 16'h8000, 16'h0000, 16'hffff);
		send_word(OP_DIV, 16'h0100, 16'h0000, 16'h0300, 16'h0000);
		send_word(OP_DIV, 16'h8000, 16'h7fff, 16'h8000, 16'h7fff);
		send_word(OP_MAG, 16'h8000, 16'h8000, 16'h0000, 16'h0000);
		send_word(OP_MAG, 16'h0300, 16'h0400, 16'h0300, 16'h0400);
		send_word(OP_MAG, 16'h0000, 16'h0001, 16'h0000, 16'h0000);
		send_word(3'd5, 16'h1111, 16'h2222, 16'h1111, 16'h2222);
		send_word(3'd6, 16'h7fff, 16'h8000, 16'h0000, 16'h0001);
		send_word(3'd7, 16'hffff, 16'hffff, 16'hffff, 16'hffff);

		// Random words; the receiver's long hold-off lands in this part
		for (int i = 0; i < RANDOM_WORDS; i++) begin
			if (i > RANDOM_WORDS - 150 && stall_done)
				calm = 1'b1;
			k = ($urandom_range(0, 15) == 0) ? 3'($urandom_range(5, 7))
				: 3'($urandom_range(0, 4));
			ar = pick_value();
			ai = pick_value();
			if ($urandom_range(0, 9) == 0)
				send_word(k, ar, ai, ar, ai);
			else if (k == OP_DIV && $urandom_range(0, 9) == 0)
				send_word(k, ar, ai, 16'h0000, 16'h0000);
			else
				send_word(k, ar, ai, pick_value(), pick_value());
		end
		calm = 1'b1;
		in_valid <= 1'b0;

		while (results.pending.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (results.mismatches == 0 && results.spurious == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end
endmodule

`default_nettype wire
